@@ hw/rtl/primaries_to_xyz_matrix_top_macros.svh @@
// Assertion helpers for the primaries to XYZ block.
`ifndef PRIMARIES_TO_XYZ_MATRIX_TOP_MACROS_SVH
`define PRIMARIES_TO_XYZ_MATRIX_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PTXM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTXM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ptxm_pkg.sv @@
`timescale 1ns / 1ps
package ptxm_pkg;

  localparam int IN_FRAC_BITS  = 16;
  localparam int OUT_FRAC_BITS = 20;

  localparam int CW   = 16;  // chromaticity width
  localparam int ZW   = 18;  // z = 1 - x - y, signed
  localparam int PW   = 36;  // 2x2 minor
  localparam int TW   = 53;  // x * minor
  localparam int DW   = 56;  // 3x3 determinant
  localparam int DENW = 73;  // D * white_y
  localparam int NUMW = 74;  // v * Dc
  localparam int NW   = 98;  // divider remainder
  localparam int QW   = 24;  // quotient / coefficient width

  localparam int NPT   = 4;  // red, green, blue, white
  localparam int NCOEF = 9;
  localparam int PT_R  = 0;
  localparam int PT_G  = 1;
  localparam int PT_B  = 2;
  localparam int PT_W  = 3;

  localparam int DIV_STAGES = QW + 1;
  localparam int NST        = 6 + DIV_STAGES + 1;
  localparam int ST_DIV0    = 6;
  localparam int ST_OUT     = NST - 1;

  localparam logic [ZW-1:0] ONE_Q = ZW'(1) << IN_FRAC_BITS;
  localparam logic signed [QW-1:0] COEF_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] COEF_MIN = {1'b1, {(QW-1){1'b0}}};

  typedef struct {
    logic [CW-1:0]        x [NPT];
    logic [CW-1:0]        y [NPT];
    logic signed [ZW-1:0] z [NPT];
    logic                 dy;
  } pts_t;

  typedef struct {
    pts_t                 p;
    logic signed [PW-1:0] pgb, prb, prg, pwb, pwg, prw;
  } minor_t;

  typedef struct {
    pts_t                 p;
    logic signed [TW-1:0] t [4][3];
  } term_t;

  typedef struct {
    pts_t                 p;
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] dc [3];
  } det_t;

  typedef struct {
    logic signed [DENW-1:0] den;
    logic signed [NUMW-1:0] num [NCOEF];
    logic                   degen;
  } prod_t;

  typedef struct {
    logic [NW-1:0] rem [NCOEF];
    logic [NW-1:0] dp;
    logic          neg [NCOEF];
    logic          degen;
  } mag_t;

  typedef struct {
    logic [NW-1:0] rem [NCOEF];
    logic [NW-1:0] dp;
    logic          neg [NCOEF];
    logic          big [NCOEF];
    logic [QW-1:0] q [NCOEF];
    logic          degen;
  } div_t;

  function automatic logic signed [PW-1:0] minor2(input logic [CW-1:0] yi,
      input logic signed [ZW-1:0] zi, input logic [CW-1:0] yj,
      input logic signed [ZW-1:0] zj);
    logic signed [PW-1:0] a, b;
    a = PW'($signed({1'b0, yi})) * PW'(zj);
    b = PW'($signed({1'b0, yj})) * PW'(zi);
    return a - b;
  endfunction

  function automatic logic signed [TW-1:0] xterm(input logic [CW-1:0] x,
      input logic signed [PW-1:0] p);
    return TW'($signed({1'b0, x})) * TW'(p);
  endfunction

endpackage

@@ hw/rtl/primaries_to_xyz_matrix_top.sv @@
`timescale 1ns / 1ps
// RGB-to-XYZ matrix from primaries and white point. One request per cycle is
// taken at full rate when the output is not stalled, and results leave in the
// order of their requests. The depth is set by the 24-bit restoring
// division (one quotient bit per stage, nine lanes side by side) behind six
// stages of determinant and product arithmetic and the saturating output
// register. Every stage has its own valid bit and a stage moves when it is
// empty or the one after it moves, so bubbles close up under backpressure.
// in_tdata holds red_x, red_y, green_x, green_y, blue_x, blue_y, white_x,
// white_y (unsigned Q0.16) from the lowest bit up; out_tdata holds coef_00
// through coef_22 (signed Q3.20, saturated), out_tuser the degenerate flag
// (zero y or singular primaries, with all coefficients zero).
`include "primaries_to_xyz_matrix_top_macros.svh"
module primaries_to_xyz_matrix_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // red_x, red_y, green_x, green_y, blue_x, blue_y, white_x, white_y
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // coef_00, coef_01, coef_02, coef_10, coef_11, coef_12, coef_20, coef_21, coef_22
  output logic [215:0] out_tdata,
  // degenerate
  output logic [0:0]   out_tuser
);

  logic [ptxm_pkg::NST-1:0] vld_r, vld_nxt, en;

  ptxm_pkg::pts_t   s1_r, s1_nxt;
  ptxm_pkg::minor_t s2_r, s2_nxt;
  ptxm_pkg::term_t  s3_r, s3_nxt;
  ptxm_pkg::det_t   s4_r, s4_nxt;
  ptxm_pkg::prod_t  s5_r, s5_nxt;
  ptxm_pkg::mag_t   s6_r, s6_nxt;
  ptxm_pkg::div_t   dv_r [ptxm_pkg::DIV_STAGES];
  ptxm_pkg::div_t   dv_nxt [ptxm_pkg::DIV_STAGES];
  logic [215:0]     data_r, data_nxt;
  logic             degen_r, degen_nxt;

  // stage moves when empty or when the next stage moves
  always_comb begin
    en[ptxm_pkg::ST_OUT] = !vld_r[ptxm_pkg::ST_OUT] || out_tready;
    for (int k = ptxm_pkg::ST_OUT - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k + 1];
    end
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_tvalid;
    end
    for (int k = 1; k < ptxm_pkg::NST; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k - 1];
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[ptxm_pkg::ST_OUT];
  assign out_tdata  = data_r;
  assign out_tuser  = degen_r;

  // lift each point: x, y, 1 - x - y
  always_comb begin
    s1_nxt.dy = 1'b0;
    for (int k = 0; k < ptxm_pkg::NPT; k++) begin
      s1_nxt.x[k] = in_tdata[32*k +: 16];
      s1_nxt.y[k] = in_tdata[32*k + 16 +: 16];
      s1_nxt.z[k] = $signed(ptxm_pkg::ONE_Q)
                    - $signed({2'b00, in_tdata[32*k +: 16]})
                    - $signed({2'b00, in_tdata[32*k + 16 +: 16]});
      if (in_tdata[32*k + 16 +: 16] == '0) begin
        s1_nxt.dy = 1'b1;
      end
    end
  end

  // 2x2 minors on the y and z rows
  always_comb begin
    s2_nxt.p   = s1_r;
    s2_nxt.pgb = ptxm_pkg::minor2(s1_r.y[ptxm_pkg::PT_G], s1_r.z[ptxm_pkg::PT_G],
                                  s1_r.y[ptxm_pkg::PT_B], s1_r.z[ptxm_pkg::PT_B]);
    s2_nxt.prb = ptxm_pkg::minor2(s1_r.y[ptxm_pkg::PT_R], s1_r.z[ptxm_pkg::PT_R],
                                  s1_r.y[ptxm_pkg::PT_B], s1_r.z[ptxm_pkg::PT_B]);
    s2_nxt.prg = ptxm_pkg::minor2(s1_r.y[ptxm_pkg::PT_R], s1_r.z[ptxm_pkg::PT_R],
                                  s1_r.y[ptxm_pkg::PT_G], s1_r.z[ptxm_pkg::PT_G]);
    s2_nxt.pwb = ptxm_pkg::minor2(s1_r.y[ptxm_pkg::PT_W], s1_r.z[ptxm_pkg::PT_W],
                                  s1_r.y[ptxm_pkg::PT_B], s1_r.z[ptxm_pkg::PT_B]);
    s2_nxt.pwg = ptxm_pkg::minor2(s1_r.y[ptxm_pkg::PT_W], s1_r.z[ptxm_pkg::PT_W],
                                  s1_r.y[ptxm_pkg::PT_G], s1_r.z[ptxm_pkg::PT_G]);
    s2_nxt.prw = ptxm_pkg::minor2(s1_r.y[ptxm_pkg::PT_R], s1_r.z[ptxm_pkg::PT_R],
                                  s1_r.y[ptxm_pkg::PT_W], s1_r.z[ptxm_pkg::PT_W]);
  end

  // x times cofactor terms for D and the three replaced-column determinants
  always_comb begin
    logic [ptxm_pkg::CW-1:0] xr, xg, xb, xw;
    xr = s2_r.p.x[ptxm_pkg::PT_R];
    xg = s2_r.p.x[ptxm_pkg::PT_G];
    xb = s2_r.p.x[ptxm_pkg::PT_B];
    xw = s2_r.p.x[ptxm_pkg::PT_W];
    s3_nxt.p       = s2_r.p;
    s3_nxt.t[0][0] = ptxm_pkg::xterm(xr, s2_r.pgb);
    s3_nxt.t[0][1] = ptxm_pkg::xterm(xg, s2_r.prb);
    s3_nxt.t[0][2] = ptxm_pkg::xterm(xb, s2_r.prg);
    s3_nxt.t[1][0] = ptxm_pkg::xterm(xw, s2_r.pgb);
    s3_nxt.t[1][1] = ptxm_pkg::xterm(xg, s2_r.pwb);
    s3_nxt.t[1][2] = ptxm_pkg::xterm(xb, s2_r.pwg);
    s3_nxt.t[2][0] = ptxm_pkg::xterm(xr, s2_r.pwb);
    s3_nxt.t[2][1] = ptxm_pkg::xterm(xw, s2_r.prb);
    s3_nxt.t[2][2] = ptxm_pkg::xterm(xb, s2_r.prw);
    s3_nxt.t[3][0] = ptxm_pkg::xterm(xr, s2_r.pwg);
    s3_nxt.t[3][1] = ptxm_pkg::xterm(xg, s2_r.prw);
    s3_nxt.t[3][2] = ptxm_pkg::xterm(xw, s2_r.prg);
  end

  always_comb begin
    logic signed [ptxm_pkg::DW-1:0] e [4][3];
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) begin
        e[i][j] = ptxm_pkg::DW'(s3_r.t[i][j]);
      end
    end
    s4_nxt.p     = s3_r.p;
    s4_nxt.d     = e[0][0] - e[0][1] + e[0][2];
    s4_nxt.dc[0] = e[1][0] - e[1][1] + e[1][2];
    s4_nxt.dc[1] = e[2][0] - e[2][1] + e[2][2];
    // green-white minor is the negated white-green one
    s4_nxt.dc[2] = e[3][2] - e[3][0] - e[3][1];
  end

  // denominator D * white_y and numerators v_c[r] * Dc
  always_comb begin
    logic signed [ptxm_pkg::ZW-1:0] v;
    s5_nxt.degen = s4_r.p.dy || (s4_r.d == '0);
    s5_nxt.den   = ptxm_pkg::DENW'(s4_r.d)
                   * ptxm_pkg::DENW'($signed({1'b0, s4_r.p.y[ptxm_pkg::PT_W]}));
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (r == 0) begin
          v = $signed({2'b00, s4_r.p.x[c]});
        end else if (r == 1) begin
          v = $signed({2'b00, s4_r.p.y[c]});
        end else begin
          v = s4_r.p.z[c];
        end
        s5_nxt.num[3*r + c] = ptxm_pkg::NUMW'(v) * ptxm_pkg::NUMW'(s4_r.dc[c]);
      end
    end
  end

  // round to nearest: floor((2|n| + |d|) / (2|d|))
  always_comb begin
    logic [ptxm_pkg::DENW-1:0] aden;
    logic [ptxm_pkg::NUMW-1:0] anum;
    aden = s5_r.den[ptxm_pkg::DENW-1] ? ptxm_pkg::DENW'(-s5_r.den)
                                      : ptxm_pkg::DENW'(s5_r.den);
    s6_nxt.dp    = ptxm_pkg::NW'(aden) << 1;
    s6_nxt.degen = s5_r.degen;
    for (int i = 0; i < ptxm_pkg::NCOEF; i++) begin
      anum = s5_r.num[i][ptxm_pkg::NUMW-1] ? ptxm_pkg::NUMW'(-s5_r.num[i])
                                           : ptxm_pkg::NUMW'(s5_r.num[i]);
      s6_nxt.rem[i] = (ptxm_pkg::NW'(anum) << (ptxm_pkg::OUT_FRAC_BITS + 1))
                      + ptxm_pkg::NW'(aden);
      s6_nxt.neg[i] = s5_r.num[i][ptxm_pkg::NUMW-1] ^ s5_r.den[ptxm_pkg::DENW-1];
    end
  end

  // division: first stage flags overflow, then one quotient bit per stage
  always_comb begin
    logic [ptxm_pkg::NW-1:0] sh;
    int b;
    dv_nxt[0].dp    = s6_r.dp;
    dv_nxt[0].degen = s6_r.degen;
    for (int i = 0; i < ptxm_pkg::NCOEF; i++) begin
      dv_nxt[0].rem[i] = s6_r.rem[i];
      dv_nxt[0].neg[i] = s6_r.neg[i];
      dv_nxt[0].q[i]   = '0;
      dv_nxt[0].big[i] = s6_r.rem[i] >= (s6_r.dp << ptxm_pkg::QW);
    end
    for (int j = 1; j < ptxm_pkg::DIV_STAGES; j++) begin
      b = ptxm_pkg::QW - j;
      sh = dv_r[j-1].dp << b;
      dv_nxt[j] = dv_r[j-1];
      for (int i = 0; i < ptxm_pkg::NCOEF; i++) begin
        if (dv_r[j-1].rem[i] >= sh) begin
          dv_nxt[j].rem[i] = dv_r[j-1].rem[i] - sh;
          dv_nxt[j].q[i][b] = 1'b1;
        end
      end
    end
  end

  // saturate and apply sign
  always_comb begin
    logic [ptxm_pkg::QW-1:0] mag;
    logic signed [ptxm_pkg::QW-1:0] cf;
    degen_nxt = dv_r[ptxm_pkg::DIV_STAGES-1].degen;
    for (int i = 0; i < ptxm_pkg::NCOEF; i++) begin
      mag = dv_r[ptxm_pkg::DIV_STAGES-1].q[i];
      if (dv_r[ptxm_pkg::DIV_STAGES-1].neg[i]) begin
        if (dv_r[ptxm_pkg::DIV_STAGES-1].big[i] || (mag > ptxm_pkg::COEF_MIN)) begin
          cf = ptxm_pkg::COEF_MIN;
        end else begin
          cf = -$signed(mag);
        end
      end else begin
        if (dv_r[ptxm_pkg::DIV_STAGES-1].big[i]
            || (mag > ptxm_pkg::QW'(ptxm_pkg::COEF_MAX))) begin
          cf = ptxm_pkg::COEF_MAX;
        end else begin
          cf = $signed(mag);
        end
      end
      if (degen_nxt) begin
        cf = '0;
      end
      data_nxt[ptxm_pkg::QW*i +: ptxm_pkg::QW] = cf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_r <= s1_nxt;
    end
    if (en[1]) begin
      s2_r <= s2_nxt;
    end
    if (en[2]) begin
      s3_r <= s3_nxt;
    end
    if (en[3]) begin
      s4_r <= s4_nxt;
    end
    if (en[4]) begin
      s5_r <= s5_nxt;
    end
    if (en[5]) begin
      s6_r <= s6_nxt;
    end
    for (int j = 0; j < ptxm_pkg::DIV_STAGES; j++) begin
      if (en[ptxm_pkg::ST_DIV0 + j]) begin
        dv_r[j] <= dv_nxt[j];
      end
    end
    if (en[ptxm_pkg::ST_OUT]) begin
      data_r  <= data_nxt;
      degen_r <= degen_nxt;
    end
  end

  `PTXM_ASSERT_NOW(a_empty_out_ready, !out_tvalid, in_tready, "idle output must not block input")
  `PTXM_ASSERT_NEXT(a_accept_loads, in_tvalid && in_tready, vld_r[0], "accepted request lost")
  `PTXM_ASSERT_NOW(a_degen_zero, out_tvalid && out_tuser[0], out_tdata == '0, "degenerate result not zero")

endmodule
